// ===== rtl/core/nns_pkg.sv =====
package nns_pkg;

  // field widths of the item and result ports
  localparam int FUNC_W   = 2;
  localparam int TEMP_W   = 16;
  localparam int HOUR_W   = 5;
  localparam int DAY_W    = 5;
  localparam int LABEL_W  = 4;
  localparam int STATUS_W = 2;
  localparam int MIDX_W   = 5;
  localparam int DIST_W   = 33;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // one stored reference entry
  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic [HOUR_W-1:0]        hour;
    logic [DAY_W-1:0]         day;
    logic [LABEL_W-1:0]       month;
  } entry_t;

endpackage

// ===== rtl/core/nearest_neighbor_search_unit.sv =====
// Nearest-neighbor search over a table of up to MAX_ENTRIES reference entries held in one
// synchronous memory. Any item other than a query on a loaded table goes from acceptance
// through the finish state to the output register. A query streams the loaded entries out
// of the single read port of the table memory one per cycle through a three-stage distance
// pipeline (absolute differences, squares, sum and compare), then drains it and finishes.
// The smallest squared distance wins and ties go to the lower index. Only one item is in
// flight at a time, but a new item is accepted while the previous result still waits in
// the output register.
module nearest_neighbor_search_unit #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // item channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [nns_pkg::FUNC_W-1:0]           in_func,
  input  logic signed [nns_pkg::TEMP_W-1:0]    in_temperature,
  input  logic [nns_pkg::HOUR_W-1:0]           in_hour,
  input  logic [nns_pkg::DAY_W-1:0]            in_day,
  input  logic [nns_pkg::LABEL_W-1:0]          in_month_label,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [nns_pkg::STATUS_W-1:0]         out_status,
  output logic [nns_pkg::MIDX_W-1:0]           out_match_index,
  output logic signed [nns_pkg::TEMP_W-1:0]    out_match_temperature,
  output logic [nns_pkg::HOUR_W-1:0]           out_match_hour,
  output logic [nns_pkg::DAY_W-1:0]            out_match_day,
  output logic [nns_pkg::LABEL_W-1:0]          out_match_month,
  output logic [nns_pkg::DIST_W-1:0]           out_min_dist_sq
);
  import nns_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int SQT_W = 2 * TEMP_W;
  localparam int SQS_W = 2 * HOUR_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] scan_cnt_r;

  // latched item
  logic [FUNC_W-1:0]        q_func_r;
  logic signed [TEMP_W-1:0] q_temp_r;
  logic [HOUR_W-1:0]        q_hour_r;
  logic [DAY_W-1:0]         q_day_r;
  logic [STATUS_W-1:0]      res_status_r;
  logic                     hit_r;

  // table memory
  entry_t mem [MAX_ENTRIES];
  entry_t rd_data_r;

  // pipeline
  logic                  v1_r, v2_r, v3_r;
  logic [IDX_W-1:0]      idx1_r, idx2_r, idx3_r;
  entry_t                ent2_r, ent3_r;
  logic [TEMP_W-1:0]     dt_r;
  logic [HOUR_W-1:0]     dh_r;
  logic [DAY_W-1:0]      dd_r;
  logic [SQT_W-1:0]      sqt_r;
  logic [SQS_W-1:0]      sqs_r;

  // running best
  logic                  found_r;
  logic [DIST_W-1:0]     best_d_r;
  logic [IDX_W-1:0]      best_idx_r;
  entry_t                best_ent_r;

  // output register
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [MIDX_W-1:0]     out_idx_r;
  entry_t                out_ent_r;
  logic [DIST_W-1:0]     out_dist_r;

  logic in_acc;
  logic issue;
  logic last_issue;
  logic slot_free;
  logic is_full;
  logic we;

  logic signed [TEMP_W:0] diff_t;
  logic [TEMP_W:0]        mag_t;
  logic [HOUR_W-1:0]      mag_h;
  logic [DAY_W-1:0]       mag_d;
  logic [DIST_W-1:0]      cand_dist;

  // handshake
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign is_full   = (count_r == CNT_W'(MAX_ENTRIES));
  assign we        = in_acc && (in_func == FUNC_APPEND) && !is_full;
  assign issue     = (state_r == ST_SCAN);
  assign last_issue = issue && (scan_cnt_r == count_r - CNT_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_func == FUNC_QUERY && count_r != '0) state_nxt = ST_SCAN;
          else state_nxt = ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (last_issue) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r && !v3_r) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      scan_cnt_r <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      found_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      if (in_acc) begin
        scan_cnt_r <= '0;
        found_r    <= 1'b0;
        if (in_func == FUNC_CLEAR) count_r <= '0;
        else if (we) count_r <= count_r + CNT_W'(1);
      end
      if (issue) scan_cnt_r <= scan_cnt_r + CNT_W'(1);
      if (v3_r && (!found_r || cand_dist < best_d_r)) found_r <= 1'b1;
      if (state_r == ST_FINISH && slot_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // latch the accepted item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_func_r <= in_func;
      q_temp_r <= in_temperature;
      q_hour_r <= in_hour;
      q_day_r  <= in_day;
      hit_r    <= (in_func == FUNC_QUERY) && (count_r != '0);
      if (in_func == FUNC_APPEND && is_full) res_status_r <= STATUS_FULL;
      else if (in_func == FUNC_QUERY && count_r == '0) res_status_r <= STATUS_EMPTY;
      else res_status_r <= STATUS_OK;
    end
  end

  // table memory: one write port for appends, one registered read port for the scan
  always_ff @(posedge clk) begin
    if (we) mem[count_r[IDX_W-1:0]] <= '{in_temperature, in_hour, in_day, in_month_label};
    rd_data_r <= mem[scan_cnt_r[IDX_W-1:0]];
  end

  // stage 1: absolute differences
  assign diff_t = {q_temp_r[TEMP_W-1], q_temp_r}
                - {rd_data_r.temperature[TEMP_W-1], rd_data_r.temperature};
  assign mag_t  = diff_t[TEMP_W] ? (TEMP_W+1)'(-diff_t) : (TEMP_W+1)'(diff_t);
  assign mag_h  = (q_hour_r >= rd_data_r.hour) ? q_hour_r - rd_data_r.hour
                                               : rd_data_r.hour - q_hour_r;
  assign mag_d  = (q_day_r >= rd_data_r.day) ? q_day_r - rd_data_r.day
                                             : rd_data_r.day - q_day_r;

  // pipeline payload
  always_ff @(posedge clk) begin
    idx1_r <= scan_cnt_r[IDX_W-1:0];
    // stage 1
    dt_r   <= mag_t[TEMP_W-1:0];
    dh_r   <= mag_h;
    dd_r   <= mag_d;
    idx2_r <= idx1_r;
    ent2_r <= rd_data_r;
    // stage 2: squares
    sqt_r  <= SQT_W'(dt_r) * SQT_W'(dt_r);
    sqs_r  <= SQS_W'(SQS_W'(dh_r) * SQS_W'(dh_r)) + SQS_W'(SQS_W'(dd_r) * SQS_W'(dd_r));
    idx3_r <= idx2_r;
    ent3_r <= ent2_r;
  end

  // stage 3: sum and keep the first smallest
  assign cand_dist = DIST_W'(sqt_r) + DIST_W'({sqs_r, 8'd0});

  always_ff @(posedge clk) begin
    if (v3_r && (!found_r || cand_dist < best_d_r)) begin
      best_d_r   <= cand_dist;
      best_idx_r <= idx3_r;
      best_ent_r <= ent3_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH && slot_free) begin
      out_status_r <= res_status_r;
      if (hit_r) begin
        out_idx_r  <= MIDX_W'(best_idx_r);
        out_ent_r  <= best_ent_r;
        out_dist_r <= best_d_r;
      end else begin
        out_idx_r  <= '0;
        out_ent_r  <= '0;
        out_dist_r <= '0;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_match_index       = out_idx_r;
  assign out_match_temperature = out_ent_r.temperature;
  assign out_match_hour        = out_ent_r.hour;
  assign out_match_day         = out_ent_r.day;
  assign out_match_month       = out_ent_r.month;
  assign out_min_dist_sq       = out_dist_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_pipe_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !(v1_r || v2_r || v3_r))
    else $error("distance pipeline busy while idle");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result loaded outside finish");

  a_query_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && hit_r) |-> found_r)
    else $error("query finished without a candidate");

  a_func_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (q_func_r == FUNC_QUERY))
    else $error("scan started for a non-query item");

endmodule

// ===== test/nearest_neighbor_search_unit_tb.sv =====
`timescale 1ns / 1ps

module nearest_neighbor_search_unit_tb;
  import nns_pkg::*;

  localparam int MAX_ENTRIES  = 32;
  localparam int RAND_ITEMS   = 1400;
  localparam int QUIET_ITEMS  = 150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int REPORT_MAX   = 10;

  // spare operation code, the block leaves the table as it is and returns an OK result
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [TEMP_W-1:0] temperature;
    logic [HOUR_W-1:0]        hour;
    logic [DAY_W-1:0]         day;
    logic [LABEL_W-1:0]       label;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [MIDX_W-1:0]        idx;
    logic signed [TEMP_W-1:0] temperature;
    logic [HOUR_W-1:0]        hour;
    logic [DAY_W-1:0]         day;
    logic [LABEL_W-1:0]       month;
    logic [DIST_W-1:0]        min_dist;
  } match_t;

  typedef struct {
    item_t  it;
    bit     typed;
    match_t want;
  } row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [FUNC_W-1:0]        in_func = '0;
  logic signed [TEMP_W-1:0] in_temperature = '0;
  logic [HOUR_W-1:0]        in_hour = '0;
  logic [DAY_W-1:0]         in_day = '0;
  logic [LABEL_W-1:0]       in_month_label = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STATUS_W-1:0]      out_status;
  logic [MIDX_W-1:0]        out_match_index;
  logic signed [TEMP_W-1:0] out_match_temperature;
  logic [HOUR_W-1:0]        out_match_hour;
  logic [DAY_W-1:0]         out_match_day;
  logic [LABEL_W-1:0]       out_match_month;
  logic [DIST_W-1:0]        out_min_dist_sq;

  // shadow copy of the entry table
  entry_t      tab [MAX_ENTRIES];
  int unsigned tab_count = 0;

  match_t match_fifo[$];
  row_t   dir_rows[$];
  int     bad_count = 0;
  int     cyc = 0;
  int     useful = 0;
  bit     quiet = 1'b0;
  int     stall_left = 0;

  nearest_neighbor_search_unit #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_temperature(in_temperature),
    .in_hour(in_hour),
    .in_day(in_day),
    .in_month_label(in_month_label),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_match_index(out_match_index),
    .out_match_temperature(out_match_temperature),
    .out_match_hour(out_match_hour),
    .out_match_day(out_match_day),
    .out_match_month(out_match_month),
    .out_min_dist_sq(out_min_dist_sq)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // cycle count and watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("[nearest_neighbor_search_unit] ERROR");
      $finish;
    end
  end

  // windows of the run where neither side idles
  function automatic bit idle_free();
    return ((cyc >> 9) & 3) == 3;
  endfunction

  // squared distance, hour and day scaled by 16 to match the temperature
  function automatic logic [DIST_W-1:0] dist_sq(item_t q, entry_t e);
    logic signed [TEMP_W:0] dt;
    logic [TEMP_W:0]        adt;
    logic [HOUR_W+3:0]      qh, eh, adh;
    logic [DAY_W+3:0]       qd, ed, adD;
    dt  = $signed({q.temperature[TEMP_W-1], q.temperature})
        - $signed({e.temperature[TEMP_W-1], e.temperature});
    adt = dt[TEMP_W] ? -dt : dt;
    qh  = {q.hour, 4'b0000};
    eh  = {e.hour, 4'b0000};
    adh = (qh > eh) ? qh - eh : eh - qh;
    qd  = {q.day, 4'b0000};
    ed  = {e.day, 4'b0000};
    adD = (qd > ed) ? qd - ed : ed - qd;
    return DIST_W'(adt) * DIST_W'(adt) + DIST_W'(adh) * DIST_W'(adh)
         + DIST_W'(adD) * DIST_W'(adD);
  endfunction

  // apply one item to the shadow table and return the result it produces
  function automatic match_t nearest_lookup(item_t it);
    match_t            r;
    logic [DIST_W-1:0] d;
    int                best;
    r = '0;
    case (it.func)
      FUNC_APPEND: begin
        if (tab_count >= MAX_ENTRIES) begin
          r.status = STATUS_FULL;
        end else begin
          tab[tab_count].temperature = it.temperature;
          tab[tab_count].hour        = it.hour;
          tab[tab_count].day         = it.day;
          tab[tab_count].month       = it.label;
          tab_count++;
        end
      end
      FUNC_QUERY: begin
        if (tab_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          // strict compare keeps the lowest index on ties
          best       = 0;
          r.min_dist = dist_sq(it, tab[0]);
          for (int i = 1; i < tab_count; i++) begin
            d = dist_sq(it, tab[i]);
            if (d < r.min_dist) begin
              best       = i;
              r.min_dist = d;
            end
          end
          r.status      = STATUS_OK;
          r.idx         = MIDX_W'(best);
          r.temperature = tab[best].temperature;
          r.hour        = tab[best].hour;
          r.day         = tab[best].day;
          r.month       = tab[best].month;
        end
      end
      FUNC_CLEAR: begin
        tab_count = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic item_t mk_item(logic [FUNC_W-1:0] f, int t, int h, int d, int l);
    item_t it;
    it.func        = f;
    it.temperature = TEMP_W'(t);
    it.hour        = HOUR_W'(h);
    it.day         = DAY_W'(d);
    it.label       = LABEL_W'(l);
    return it;
  endfunction

  // directed row checked by the shadow model
  function automatic void row(logic [FUNC_W-1:0] f, int t, int h, int d, int l);
    row_t r;
    r.it    = mk_item(f, t, h, d, l);
    r.typed = 1'b0;
    r.want  = '0;
    dir_rows.push_back(r);
  endfunction

  // directed row with its result written out
  function automatic void row_x(logic [FUNC_W-1:0] f, int t, int h, int d, int l,
                                logic [STATUS_W-1:0] st, int ix, int mt, int mh, int md,
                                int mm, logic [DIST_W-1:0] want_dist);
    row_t r;
    r.it               = mk_item(f, t, h, d, l);
    r.typed            = 1'b1;
    r.want.status      = st;
    r.want.idx         = MIDX_W'(ix);
    r.want.temperature = TEMP_W'(mt);
    r.want.hour        = HOUR_W'(mh);
    r.want.day         = DAY_W'(md);
    r.want.month       = LABEL_W'(mm);
    r.want.min_dist    = want_dist;
    dir_rows.push_back(r);
  endfunction

  function automatic item_t rand_item(logic [FUNC_W-1:0] f);
    item_t it;
    it.func        = f;
    it.temperature = TEMP_W'($urandom);
    it.hour        = HOUR_W'($urandom);
    it.day         = DAY_W'($urandom);
    it.label       = LABEL_W'($urandom);
    return it;
  endfunction

  // mostly lands close to a loaded entry, so ties and small distances show up
  function automatic item_t near_item(logic [FUNC_W-1:0] f);
    item_t  it;
    entry_t e;
    it = rand_item(f);
    if (tab_count != 0 && $urandom_range(0, 3) != 0) begin
      e = tab[$urandom_range(0, tab_count - 1)];
      it.temperature = e.temperature + TEMP_W'($urandom_range(0, 32)) - TEMP_W'(16);
      if ($urandom_range(0, 2) == 0) it.temperature = e.temperature;
      it.hour = e.hour + HOUR_W'($urandom_range(0, 2)) - HOUR_W'(1);
      if ($urandom_range(0, 1) == 0) it.day = e.day;
    end
    return it;
  endfunction

  // offer one item and wait for it to be taken
  task automatic send_item(input item_t it, input bit typed, input match_t want);
    match_t calc;
    if (!quiet && !idle_free() && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= it.func;
    in_temperature <= it.temperature;
    in_hour        <= it.hour;
    in_day         <= it.day;
    in_month_label <= it.label;
    do @(posedge clk); while (in_stall);
    calc = nearest_lookup(it);
    match_fifo.push_back(typed ? want : calc);
    if (it.func != FUNC_UNUSED) useful++;
  endtask

  // hold the sender until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (match_fifo.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic note_bad(input string what, input match_t want, input match_t got);
    bad_count++;
    if (bad_count <= REPORT_MAX)
      $display({"%0t %s: want st=%0d ix=%0d t=%0d h=%0d d=%0d m=%0d dist=%0d",
                " | got st=%0d ix=%0d t=%0d h=%0d d=%0d m=%0d dist=%0d"},
               $time, what, want.status, want.idx, want.temperature, want.hour, want.day,
               want.month, want.min_dist, got.status, got.idx, got.temperature, got.hour,
               got.day, got.month, got.min_dist);
  endtask

  // result side: random stall bursts
  always @(posedge clk) begin
    if (!rst_n || quiet || idle_free()) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each taken result with the oldest pending one
  always @(posedge clk) begin
    match_t got;
    match_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.status      = out_status;
      got.idx         = out_match_index;
      got.temperature = out_match_temperature;
      got.hour        = out_match_hour;
      got.day         = out_match_day;
      got.month       = out_match_month;
      got.min_dist    = out_min_dist_sq;
      if (match_fifo.size() == 0) begin
        note_bad("item result with nothing pending", '0, got);
      end else begin
        want = match_fifo.pop_front();
        if (got.status !== want.status || got.idx !== want.idx
            || got.temperature !== want.temperature || got.hour !== want.hour
            || got.day !== want.day || got.month !== want.month
            || got.min_dist !== want.min_dist)
          note_bad("mismatch", want, got);
      end
    end
  end

  // stimulus
  initial begin
    item_t it;
    int    n;
    bit    paused;
    paused = 1'b0;

    // empty table, spare code, extremes of every field
    row_x(FUNC_QUERY, 0, 0, 0, 0, STATUS_EMPTY, 0, 0, 0, 0, 0, '0);
    row_x(FUNC_UNUSED, -1, 31, 31, 15, STATUS_OK, 0, 0, 0, 0, 0, '0);
    row_x(FUNC_APPEND, -32768, 0, 1, 0, STATUS_OK, 0, 0, 0, 0, 0, '0);
    row_x(FUNC_APPEND, 32767, 31, 31, 15, STATUS_OK, 0, 0, 0, 0, 0, '0);
    row_x(FUNC_QUERY, 32767, 31, 31, 0, STATUS_OK, 1, 32767, 31, 31, 15, '0);
    row_x(FUNC_QUERY, -32768, 0, 1, 9, STATUS_OK, 0, -32768, 0, 1, 0, '0);
    row(FUNC_QUERY, 32767, 0, 0, 0);
    row(FUNC_QUERY, 0, 12, 15, 3);
    // clear, then query of the emptied table
    row_x(FUNC_CLEAR, 5, 5, 5, 5, STATUS_OK, 0, 0, 0, 0, 0, '0);
    row_x(FUNC_QUERY, 0, 0, 0, 0, STATUS_EMPTY, 0, 0, 0, 0, 0, '0);
    // largest possible distance
    row_x(FUNC_APPEND, -32768, 0, 0, 7, STATUS_OK, 0, 0, 0, 0, 0, '0);
    row_x(FUNC_QUERY, 32767, 31, 31, 0, STATUS_OK, 0, -32768, 0, 0, 7, 33'd4295328257);
    // ties go to the lower index
    row_x(FUNC_CLEAR, 0, 0, 0, 0, STATUS_OK, 0, 0, 0, 0, 0, '0);
    row(FUNC_APPEND, 100, 5, 5, 1);
    row(FUNC_APPEND, 100, 5, 5, 2);
    row(FUNC_APPEND, 132, 5, 5, 3);
    row_x(FUNC_QUERY, 100, 5, 5, 0, STATUS_OK, 0, 100, 5, 5, 1, '0);
    row(FUNC_QUERY, 116, 5, 5, 0);
    row(FUNC_QUERY, 132, 5, 5, 0);
    row_x(FUNC_UNUSED, 0, 0, 0, 0, STATUS_OK, 0, 0, 0, 0, 0, '0);
    row(FUNC_QUERY, -1, 23, 1, 0);
    row(FUNC_APPEND, -1, 0, 31, 15);
    row(FUNC_QUERY, -1, 0, 31, 0);

    // reset
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    drain_results();

    // random part: mostly fill-and-query sequences, some noise
    useful = 0;
    while (useful < RAND_ITEMS) begin
      quiet = (useful >= RAND_ITEMS - QUIET_ITEMS);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          it = rand_item(FUNC_W'($urandom_range(0, 3)));
          send_item(it, 1'b0, '0);
        end
      end else begin
        if ($urandom_range(0, 3) == 0) send_item(rand_item(FUNC_CLEAR), 1'b0, '0);
        // occasionally overfill the table
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 6);
        repeat (n) send_item(near_item(FUNC_APPEND), 1'b0, '0);
        repeat ($urandom_range(1, 6)) send_item(near_item(FUNC_QUERY), 1'b0, '0);
      end
      if (!paused && useful >= RAND_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end

    // wind down
    in_valid <= 1'b0;
    while (match_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_count == 0 && match_fifo.size() == 0) begin
      $display("[nearest_neighbor_search_unit] OK");
    end else begin
      $display("[nearest_neighbor_search_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/nns_pkg.sv
rtl/core/nearest_neighbor_search_unit.sv
test/nearest_neighbor_search_unit_tb.sv
